[hdl/iac_pkg.sv]
// Shared types and constants for the in-place array compaction unit.
// No dependencies.
`default_nettype none

package iac_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int DATA_W    = 64;
    localparam int TAG_W     = 32;
    localparam int SLOT_W    = 10;
    localparam int REQ_W     = 2;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic signed [TAG_W-1:0] EMPTY_TAG = -32'sd1;
    localparam logic [CFG_W-1:0] COUNT_MAX = {CFG_W{1'b1}};
    localparam logic [CFG_W-1:0] FILL_BOUND_RST = 11'd0;
    localparam logic [CFG_W-1:0] ARRAY_LENGTH_RST = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_BOUND   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_LENGTH = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE   = 2'd0,
        REQ_COMPACT = 2'd1,
        REQ_READ    = 2'd2
    } req_code_t;

    typedef struct packed {
        logic [DATA_W-1:0]       x;
        logic [DATA_W-1:0]       y;
        logic signed [TAG_W-1:0] tag;
    } rec_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SLOT_W-1:0] slot_index;
        rec_t              rec;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]       payload_x;
        logic [DATA_W-1:0]       payload_y;
        logic signed [TAG_W-1:0] tag;
        logic [CFG_W-1:0]        hole_count;
        logic [CFG_W-1:0]        mover_count;
        logic [CFG_W-1:0]        pair_count;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SCAN,
        ST_RD_G,
        ST_CHK_G,
        ST_RD_M,
        ST_CHK_M,
        ST_WR_M
    } state_t;

endpackage

`default_nettype wire

[hdl/iac_store.sv]
// Record memory: one write port, one read port, registered read data.
// Depends on iac_pkg.
`default_nettype none

module iac_store #(
    parameter int DEPTH = iac_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire iac_pkg::rec_t wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output iac_pkg::rec_t      rdata
);
    import iac_pkg::*;

    rec_t mem [DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/iac_ctrl.sv]
// Request sequencer: writes, reads, and the two-pass compaction walk over the store.
// Depends on iac_pkg; drives the ports of iac_store.
`default_nettype none

module iac_ctrl #(
    parameter int DEPTH = iac_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire iac_pkg::req_t               req,
    input  wire logic [iac_pkg::CFG_W-1:0]   fill_bound,
    input  wire logic [iac_pkg::CFG_W-1:0]   array_length,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output iac_pkg::res_t                    res,
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output iac_pkg::rec_t                    mem_wdata,
    output logic                             mem_re,
    output logic [AW-1:0]                    mem_raddr,
    input  wire iac_pkg::rec_t               mem_rdata
);
    import iac_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;
    localparam int IW = (AW + 1 > SLOT_W) ? AW + 1 : SLOT_W;

    function automatic logic [CFG_W-1:0] sat_cnt(input logic [CW-1:0] c);
        logic [LW-1:0] e;
        begin
            e = LW'(c);
            sat_cnt = (e > LW'(COUNT_MAX)) ? COUNT_MAX : e[CFG_W-1:0];
        end
    endfunction

    state_t state_reg, state_next;
    res_t   res_reg, res_next;
    logic   res_vld_reg, res_vld_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] bnd_reg, bnd_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          pv_reg, pv_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic [CW-1:0] gap_cnt_reg, gap_cnt_next;
    logic [CW-1:0] mov_cnt_reg, mov_cnt_next;
    logic [CW-1:0] swaps_reg, swaps_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] gp_reg, gp_next;
    logic [CW-1:0] mp_reg, mp_next;
    rec_t          grec_reg, grec_next;

    logic          res_take;
    logic [LW-1:0] alen_ext, len_ext, nv_ext, bnd_ext;
    logic [IW-1:0] sidx_ext;
    logic          in_range;
    logic [AW-1:0] slot_addr;
    logic          issue;
    logic          is_empty;
    logic [CW-1:0] min_cnt;
    logic [CW-1:0] gp_inc, mp_inc, k_inc;

    assign res_take  = res_vld_reg && res_ready;
    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    assign alen_ext  = LW'(array_length);
    assign len_ext   = (alen_ext > LW'(DEPTH)) ? LW'(DEPTH) : alen_ext;
    assign nv_ext    = LW'(fill_bound);
    assign bnd_ext   = (nv_ext < len_ext) ? nv_ext : len_ext;
    assign sidx_ext  = IW'(req.slot_index);
    assign in_range  = sidx_ext < IW'(DEPTH);
    assign slot_addr = sidx_ext[AW-1:0];
    assign is_empty  = (mem_rdata.tag == EMPTY_TAG);
    assign min_cnt   = (gap_cnt_reg < mov_cnt_reg) ? gap_cnt_reg : mov_cnt_reg;
    assign issue     = scan_reg < len_reg;
    assign gp_inc    = gp_reg + 1'b1;
    assign mp_inc    = mp_reg + 1'b1;
    assign k_inc     = k_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            res_vld_reg <= 1'b0;
            pv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            res_vld_reg <= res_vld_next;
            pv_reg      <= pv_next;
        end
        res_reg     <= res_next;
        len_reg     <= len_next;
        bnd_reg     <= bnd_next;
        scan_reg    <= scan_next;
        pidx_reg    <= pidx_next;
        gap_cnt_reg <= gap_cnt_next;
        mov_cnt_reg <= mov_cnt_next;
        swaps_reg   <= swaps_next;
        k_reg       <= k_next;
        gp_reg      <= gp_next;
        mp_reg      <= mp_next;
        grec_reg    <= grec_next;
    end

    always_comb begin
        state_next   = state_reg;
        res_next     = res_reg;
        res_vld_next = res_vld_reg && !res_take;
        len_next     = len_reg;
        bnd_next     = bnd_reg;
        scan_next    = scan_reg;
        pv_next      = pv_reg;
        pidx_next    = pidx_reg;
        gap_cnt_next = gap_cnt_reg;
        mov_cnt_next = mov_cnt_reg;
        swaps_next   = swaps_reg;
        k_next       = k_reg;
        gp_next      = gp_reg;
        mp_next      = mp_reg;
        grec_next    = grec_reg;
        in_ready     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = gp_reg[AW-1:0];
        mem_wdata    = grec_reg;
        mem_re       = 1'b0;
        mem_raddr    = scan_reg[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                in_ready = !res_vld_reg || res_ready;
                if (in_valid && in_ready) begin
                    case (req.req_type)
                        REQ_WRITE: begin
                            mem_we       = in_range;
                            mem_waddr    = slot_addr;
                            mem_wdata    = req.rec;
                            res_next     = '0;
                            res_vld_next = 1'b1;
                        end
                        REQ_READ: begin
                            if (in_range) begin
                                mem_re     = 1'b1;
                                mem_raddr  = slot_addr;
                                state_next = ST_RD_WAIT;
                            end else begin
                                res_next     = '0;
                                res_vld_next = 1'b1;
                            end
                        end
                        REQ_COMPACT: begin
                            len_next     = len_ext[CW-1:0];
                            bnd_next     = bnd_ext[CW-1:0];
                            scan_next    = '0;
                            pv_next      = 1'b0;
                            gap_cnt_next = '0;
                            mov_cnt_next = '0;
                            state_next   = ST_SCAN;
                        end
                        default: begin
                            res_next     = '0;
                            res_vld_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                res_next           = '0;
                res_next.payload_x = mem_rdata.x;
                res_next.payload_y = mem_rdata.y;
                res_next.tag       = mem_rdata.tag;
                res_vld_next       = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_SCAN: begin
                mem_re    = issue;
                mem_raddr = scan_reg[AW-1:0];
                pv_next   = issue;
                pidx_next = scan_reg;
                if (issue) begin
                    scan_next = scan_reg + 1'b1;
                end
                if (pv_reg) begin
                    if (is_empty && (pidx_reg < bnd_reg)) begin
                        gap_cnt_next = gap_cnt_reg + 1'b1;
                    end
                    if (!is_empty && (pidx_reg >= bnd_reg)) begin
                        mov_cnt_next = mov_cnt_reg + 1'b1;
                    end
                end
                if (!issue && !pv_reg) begin
                    swaps_next = min_cnt;
                    k_next     = '0;
                    gp_next    = '0;
                    mp_next    = bnd_reg;
                    if (min_cnt == '0) begin
                        res_next             = '0;
                        res_next.hole_count  = sat_cnt(gap_cnt_reg);
                        res_next.mover_count = sat_cnt(mov_cnt_reg);
                        res_next.pair_count  = sat_cnt(min_cnt);
                        res_vld_next         = 1'b1;
                        state_next           = ST_IDLE;
                    end else begin
                        state_next = ST_RD_G;
                    end
                end
            end
            ST_RD_G: begin
                mem_re     = 1'b1;
                mem_raddr  = gp_reg[AW-1:0];
                state_next = ST_CHK_G;
            end
            ST_CHK_G: begin
                if (is_empty) begin
                    grec_next  = mem_rdata;
                    state_next = ST_RD_M;
                end else begin
                    gp_next   = gp_inc;
                    mem_re    = 1'b1;
                    mem_raddr = gp_inc[AW-1:0];
                end
            end
            ST_RD_M: begin
                mem_re     = 1'b1;
                mem_raddr  = mp_reg[AW-1:0];
                state_next = ST_CHK_M;
            end
            ST_CHK_M: begin
                if (!is_empty) begin
                    mem_we     = 1'b1;
                    mem_waddr  = gp_reg[AW-1:0];
                    mem_wdata  = mem_rdata;
                    state_next = ST_WR_M;
                end else begin
                    mp_next   = mp_inc;
                    mem_re    = 1'b1;
                    mem_raddr = mp_inc[AW-1:0];
                end
            end
            ST_WR_M: begin
                mem_we    = 1'b1;
                mem_waddr = mp_reg[AW-1:0];
                mem_wdata = grec_reg;
                gp_next   = gp_inc;
                mp_next   = mp_inc;
                k_next    = k_inc;
                if (k_inc == swaps_reg) begin
                    res_next             = '0;
                    res_next.hole_count  = sat_cnt(gap_cnt_reg);
                    res_next.mover_count = sat_cnt(mov_cnt_reg);
                    res_next.pair_count  = sat_cnt(swaps_reg);
                    res_vld_next         = 1'b1;
                    state_next           = ST_IDLE;
                end else begin
                    state_next = ST_RD_G;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a pending result is never overwritten before it is taken
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_vld_reg && !res_ready |=> res_vld_reg && $stable(res_reg))
        else $error("pending result changed before it was taken");

    // counting pass never modifies the store
    a_scan_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !mem_we)
        else $error("store written during counting pass");

    a_swap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR_M) |-> (k_reg < swaps_reg))
        else $error("more swaps than counted pairs");

    a_gap_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK_G) |-> (gp_reg < bnd_reg))
        else $error("gap pointer left the compacted region");

    a_mover_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK_M) |-> (mp_reg >= bnd_reg) && (mp_reg < len_reg))
        else $error("mover pointer outside covered slots");

endmodule

`default_nettype wire

[hdl/inplace_array_compaction_unit.sv]
// Top level of the in-place array compaction unit: configuration registers,
// result output register, sequencer and record memory. Depends on iac_pkg,
// iac_ctrl and iac_store.
//
// A write item goes to the record memory as it is taken; writes stream back to back
// while the result side keeps taking results. A read item waits for the registered
// read data of the record memory. A compact item makes a counting pass over the L
// covered slots, then a swap walk for S swaps, both bound by the single read port
// of the record memory. One item is worked on at a time; a finished result waits in an
// output register while the next item is taken. The store has no reset pass: a slot
// holds a defined record only once written.
`default_nettype none

module inplace_array_compaction_unit #(
    parameter int DEPTH = iac_pkg::DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [iac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [iac_pkg::CFG_W-1:0]         cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [iac_pkg::REQ_W-1:0]         s_req_type,
    input  wire logic [iac_pkg::SLOT_W-1:0]        s_slot_index,
    input  wire logic [iac_pkg::DATA_W-1:0]        s_payload_x,
    input  wire logic [iac_pkg::DATA_W-1:0]        s_payload_y,
    input  wire logic signed [iac_pkg::TAG_W-1:0]  s_tag_in,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [iac_pkg::DATA_W-1:0]             m_payload_x_out,
    output logic [iac_pkg::DATA_W-1:0]             m_payload_y_out,
    output logic signed [iac_pkg::TAG_W-1:0]       m_tag_out,
    output logic [iac_pkg::CFG_W-1:0]              m_hole_count,
    output logic [iac_pkg::CFG_W-1:0]              m_mover_count,
    output logic [iac_pkg::CFG_W-1:0]              m_pair_count
);
    import iac_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [CFG_W-1:0] fill_bound_reg, fill_bound_next;
    logic [CFG_W-1:0] array_length_reg, array_length_next;
    logic             m_valid_reg, m_valid_next;
    res_t             m_res_reg, m_res_next;

    req_t          req;
    res_t          res;
    logic          res_valid;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    rec_t          mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    rec_t          mem_rdata;

    assign req.req_type   = s_req_type;
    assign req.slot_index = s_slot_index;
    assign req.rec.x      = s_payload_x;
    assign req.rec.y      = s_payload_y;
    assign req.rec.tag    = s_tag_in;

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        fill_bound_next   = fill_bound_reg;
        array_length_next = array_length_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FILL_BOUND:   fill_bound_next   = cfg_wr_data;
                CFG_ARRAY_LENGTH: array_length_next = cfg_wr_data;
                default: begin
                    fill_bound_next = fill_bound_reg;
                end
            endcase
        end
        m_valid_next = (m_valid_reg && !m_ready) || res_valid;
        m_res_next   = (res_valid && res_ready) ? res : m_res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_bound_reg   <= FILL_BOUND_RST;
            array_length_reg <= ARRAY_LENGTH_RST;
            m_valid_reg      <= 1'b0;
        end else begin
            fill_bound_reg   <= fill_bound_next;
            array_length_reg <= array_length_next;
            m_valid_reg      <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_x_out = m_res_reg.payload_x;
    assign m_payload_y_out = m_res_reg.payload_y;
    assign m_tag_out       = m_res_reg.tag;
    assign m_hole_count    = m_res_reg.hole_count;
    assign m_mover_count   = m_res_reg.mover_count;
    assign m_pair_count    = m_res_reg.pair_count;

    iac_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .req          (req),
        .fill_bound   (fill_bound_reg),
        .array_length (array_length_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    iac_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

[dv/inplace_array_compaction_unit_tb.sv]
// Testbench for inplace_array_compaction_unit: directed and random write, read,
// compact and unused requests, checked against a scoreboard that keeps its own store.
// Depends on iac_pkg and the RTL under hdl/.
module inplace_array_compaction_unit_tb;
    import iac_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    class compaction_scoreboard;
        rec_t             slots [DEPTH_DEF];
        logic [CFG_W-1:0] boundary;
        logic [CFG_W-1:0] span;
        res_t             pending_results [$];
        int               fail_count;

        function new();
            foreach (slots[i]) slots[i] = '0;
            boundary   = FILL_BOUND_RST;
            span       = ARRAY_LENGTH_RST;
            fail_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_FILL_BOUND) begin
                boundary = value;
            end else if (idx == CFG_ARRAY_LENGTH) begin
                span = value;
            end
        endfunction

        function logic [CFG_W-1:0] clip_count(int count);
            return (count > COUNT_MAX) ? COUNT_MAX : CFG_W'(count);
        endfunction

        // gaps below the boundary pair in ascending order with movers at or above it
        function res_t compact_store();
            res_t r;
            int   covered;
            int   gap_slots [$];
            int   mover_slots [$];
            int   pairs;
            rec_t held;
            r = '0;
            covered = (span > DEPTH_DEF) ? DEPTH_DEF : int'(span);
            for (int i = 0; i < covered; i++) begin
                if (i < boundary) begin
                    if (slots[i].tag == EMPTY_TAG) gap_slots.push_back(i);
                end else if (slots[i].tag != EMPTY_TAG) begin
                    mover_slots.push_back(i);
                end
            end
            pairs = (gap_slots.size() < mover_slots.size()) ? gap_slots.size()
                                                            : mover_slots.size();
            for (int k = 0; k < pairs; k++) begin
                held                  = slots[gap_slots[k]];
                slots[gap_slots[k]]   = slots[mover_slots[k]];
                slots[mover_slots[k]] = held;
            end
            r.hole_count  = clip_count(gap_slots.size());
            r.mover_count = clip_count(mover_slots.size());
            r.pair_count  = clip_count(pairs);
            return r;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] idx,
                                   logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                                   logic signed [TAG_W-1:0] ptag);
            res_t r;
            r = '0;
            case (req)
                REQ_WRITE: begin
                    slots[idx].x   = px;
                    slots[idx].y   = py;
                    slots[idx].tag = ptag;
                end
                REQ_COMPACT: r = compact_store();
                REQ_READ: begin
                    r.payload_x = slots[idx].x;
                    r.payload_y = slots[idx].y;
                    r.tag       = slots[idx].tag;
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_results.size() == 0) begin
                $error("result item with no request outstanding");
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("payload_x_out", want.payload_x, got.payload_x);
            compare_field("payload_y_out", want.payload_y, got.payload_y);
            compare_field("tag_out", DATA_W'(want.tag), DATA_W'(got.tag));
            compare_field("hole_count", DATA_W'(want.hole_count), DATA_W'(got.hole_count));
            compare_field("mover_count", DATA_W'(want.mover_count),
                          DATA_W'(got.mover_count));
            compare_field("pair_count", DATA_W'(want.pair_count), DATA_W'(got.pair_count));
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [REQ_W-1:0]        s_req_type;
    logic [SLOT_W-1:0]       s_slot_index;
    logic [DATA_W-1:0]       s_payload_x;
    logic [DATA_W-1:0]       s_payload_y;
    logic signed [TAG_W-1:0] s_tag_in;
    logic                    m_valid;
    logic                    m_ready;
    logic [DATA_W-1:0]       m_payload_x_out;
    logic [DATA_W-1:0]       m_payload_y_out;
    logic signed [TAG_W-1:0] m_tag_out;
    logic [CFG_W-1:0]        m_hole_count;
    logic [CFG_W-1:0]        m_mover_count;
    logic [CFG_W-1:0]        m_pair_count;

    compaction_scoreboard sb;
    bit                   slot_written [DEPTH_DEF];
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   recv_hold;

    inplace_array_compaction_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_slot_index    (s_slot_index),
        .s_payload_x     (s_payload_x),
        .s_payload_y     (s_payload_y),
        .s_tag_in        (s_tag_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_x_out (m_payload_x_out),
        .m_payload_y_out (m_payload_y_out),
        .m_tag_out       (m_tag_out),
        .m_hole_count    (m_hole_count),
        .m_mover_count   (m_mover_count),
        .m_pair_count    (m_pair_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge aclk) begin : item_monitor
        res_t seen;
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_req_type, s_slot_index, s_payload_x, s_payload_y, s_tag_in);
        end
        if (aresetn && m_valid && m_ready) begin
            seen.payload_x   = m_payload_x_out;
            seen.payload_y   = m_payload_y_out;
            seen.tag         = m_tag_out;
            seen.hole_count  = m_hole_count;
            seen.mover_count = m_mover_count;
            seen.pair_count  = m_pair_count;
            sb.check_result(seen);
        end
    end

    // result side: long hold-off when requested, else random stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] idx,
                             input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                             input logic signed [TAG_W-1:0] ptag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_slot_index <= idx;
        s_payload_x  <= px;
        s_payload_y  <= py;
        s_tag_in     <= ptag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_slot(input int slot, input logic [DATA_W-1:0] px,
                              input logic [DATA_W-1:0] py, input logic signed [TAG_W-1:0] ptag);
        slot_written[slot] = 1'b1;
        send_item(REQ_WRITE, SLOT_W'(slot), px, py, ptag);
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic drain_results();
        wait_results();
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        sb.set_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic signed [TAG_W-1:0] random_tag();
        case ($urandom_range(9))
            0, 1, 2, 3: return EMPTY_TAG;
            4: return {1'b1, {(TAG_W-1){1'b0}}};
            5: return {1'b0, {(TAG_W-1){1'b1}}};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request(input int window, input int compact_pct);
        int                      pick;
        int                      slot;
        int                      other;
        logic [DATA_W-1:0]       px;
        logic [DATA_W-1:0]       py;
        pick = $urandom_range(99);
        px   = {$urandom, $urandom};
        py   = {$urandom, $urandom};
        slot = $urandom_range(window - 1);
        if (pick < compact_pct) begin
            send_item(REQ_COMPACT, SLOT_W'($urandom_range(DEPTH_DEF - 1)), px, py,
                      random_tag());
        end else if (pick < compact_pct + 4) begin
            send_item(REQ_UNUSED, SLOT_W'($urandom_range(DEPTH_DEF - 1)), px, py, $urandom);
        end else if (pick < compact_pct + 50) begin
            if ($urandom_range(3) == 0) slot = $urandom_range(DEPTH_DEF - 1);
            write_slot(slot, px, py, random_tag());
        end else begin
            other = $urandom_range(DEPTH_DEF - 1);
            if ($urandom_range(4) == 0 && slot_written[other]) slot = other;
            send_item(REQ_READ, SLOT_W'(slot), px, py, $urandom);
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] nv, input logic [CFG_W-1:0] len,
                             input int mode, input int count, input int hold);
        int covered;
        int window;
        int compact_pct;
        drain_results();
        write_reg(CFG_FILL_BOUND, nv);
        write_reg(CFG_ARRAY_LENGTH, len);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
        covered     = (len > DEPTH_DEF) ? DEPTH_DEF : int'(len);
        window      = (covered < 8) ? 8 : covered;
        compact_pct = (covered > 128) ? 3 : 20;
        // every slot a compact or read may touch must hold a record
        for (int s = 0; s < window; s++) begin
            if (!slot_written[s]) write_slot(s, {$urandom, $urandom}, {$urandom, $urandom},
                                             random_tag());
        end
        recv_hold = hold;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_results();
            random_request(window, compact_pct);
        end
    endtask

    initial begin
        int len;
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_req_type     = REQ_WRITE;
        s_slot_index   = '0;
        s_payload_x    = '0;
        s_payload_y    = '0;
        s_tag_in       = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: gaps at 1 and 3 below the boundary, movers at 4 and 6
        write_reg(CFG_FILL_BOUND, 11'd4);
        write_reg(CFG_ARRAY_LENGTH, 11'd8);
        write_slot(0, '0, '0, '0);
        write_slot(1, '1, '1, EMPTY_TAG);
        write_slot(2, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 32'sh7fff_ffff);
        write_slot(3, 64'h1, 64'h2, EMPTY_TAG);
        write_slot(4, 64'h8000_0000_0000_0000, 64'h3, 32'sh8000_0000);
        write_slot(5, 64'h4, 64'h5, EMPTY_TAG);
        write_slot(6, 64'h6, 64'h7fff_ffff_ffff_ffff, 32'sd5);
        write_slot(7, 64'h8, 64'h9, EMPTY_TAG);
        write_slot(DEPTH_DEF - 1, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, -32'sd2);
        send_item(REQ_READ, SLOT_W'(DEPTH_DEF - 1), '0, '0, '0);
        send_item(REQ_READ, 1, '0, '0, '0);
        send_item(REQ_COMPACT, 0, '0, '0, '0);
        send_item(REQ_READ, 1, '1, '1, '1);
        send_item(REQ_READ, 4, '0, '0, '0);
        send_item(REQ_COMPACT, '1, '1, '1, '1);
        send_item(REQ_UNUSED, 3, '1, '1, '1);
        send_item(REQ_READ, 0, '0, '0, '0);
        // boundary beyond the covered length, then nothing covered
        drain_results();
        write_reg(CFG_FILL_BOUND, 11'd10);
        send_item(REQ_COMPACT, 0, '0, '0, '0);
        drain_results();
        write_reg(CFG_ARRAY_LENGTH, 11'd0);
        send_item(REQ_COMPACT, 0, '0, '0, '0);
        send_item(REQ_READ, 3, '0, '0, '0);

        run_phase(CFG_W'($urandom_range(32)), 11'd32, 0, 100, 300);
        run_phase(11'd512, 11'd1024, 1, 100, 0);
        run_phase(11'd0, 11'd0, 2, 100, 0);
        run_phase(11'd2047, 11'd2047, 3, 100, 0);
        run_phase(11'd0, 11'd16, 0, 100, 0);
        run_phase(11'd64, 11'd64, 1, 100, 0);
        for (int p = 6; p < 10; p++) begin
            len = $urandom_range(64, 1);
            run_phase(CFG_W'($urandom_range(len + 8)), CFG_W'(len), p % 4, 100, 0);
        end

        wait_results();
        repeat (20) @(negedge aclk);
        if (sb.fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
